@@ hw/rtl/bitmap_priority_run_queue_defines.svh @@
// ============================================================================
// Assertion macros for the bitmap priority run queue
// Concurrent assertion wrappers; empty under synthesis.
// ============================================================================
`ifndef BITMAP_PRIORITY_RUN_QUEUE_DEFINES_SVH
`define BITMAP_PRIORITY_RUN_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// clocked check, held off while reset is asserted (active low)
`define BRQ_ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("run queue assertion failed");

// clocked check, active during reset too
`define BRQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("run queue assertion failed");

`else

`define BRQ_ASSERT_RST(label, clk, rstn, prop)
`define BRQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ hw/rtl/brq_pkg.sv @@
// ============================================================================
// brq_pkg
// Command and status codes, item and result types of the run queue.
// ============================================================================
package brq_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 5;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INS_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REM_IGNORED = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FIELD_W-1:0] task_id;
        logic [FIELD_W-1:0] prio;
        logic               slice_left;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  next_task;
        logic                found;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

@@ hw/rtl/brq_prio_enc.sv @@
// ============================================================================
// brq_prio_enc
// Highest-set-bit encoder over the level bitmap.
// ============================================================================
module brq_prio_enc #(
    parameter int WIDTH = 32,
    parameter int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
    input  logic [WIDTH-1:0] req,
    output logic [IDX_W-1:0] idx,
    output logic             any
);

    always_comb begin
        idx = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (req[i]) begin
                idx = IDX_W'(i);
            end
        end
        any = |req;
    end

endmodule

@@ hw/rtl/brq_queue_core.sv @@
// ============================================================================
// brq_queue_core
// Per-level linked lists, level bitmap and queued flags; one command per
// enabled cycle, result produced combinationally.
// ============================================================================
module brq_queue_core #(
    parameter int LEVELS = 32,
    parameter int TASKS  = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             exec_en,
    input  brq_pkg::item_t   item,
    output brq_pkg::result_t result
);

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int TASK_W = $clog2(TASKS);

    logic [LEVELS-1:0] level_bitmap_reg, level_bitmap_next;
    logic [TASKS-1:0]  is_queued_reg, is_queued_next;

    logic [LVL_W-1:0]  task_level_reg [TASKS];
    logic [TASK_W-1:0] next_link_reg  [TASKS];
    logic [TASK_W-1:0] prev_link_reg  [TASKS];
    logic [TASK_W-1:0] level_head_reg [LEVELS];
    logic [TASK_W-1:0] level_tail_reg [LEVELS];

    logic [TASK_W-1:0] tid;
    logic              tid_ok;
    logic [LVL_W-1:0]  lv_ins;
    logic [LVL_W-1:0]  lv_top;
    logic              any_level;
    logic [LVL_W-1:0]  lv_sel;
    logic [TASK_W-1:0] head_rd;
    logic [TASK_W-1:0] tail_rd;
    logic              first;
    logic              last;

    logic              tl_we;
    logic              nl_we;
    logic [TASK_W-1:0] nl_addr;
    logic [TASK_W-1:0] nl_data;
    logic              pl_we;
    logic [TASK_W-1:0] pl_addr;
    logic [TASK_W-1:0] pl_data;
    logic              hd_we;
    logic [TASK_W-1:0] hd_data;
    logic              tt_we;
    logic [TASK_W-1:0] tt_data;

    brq_prio_enc #(
        .WIDTH (LEVELS),
        .IDX_W (LVL_W)
    ) u_prio_enc (
        .req (level_bitmap_reg),
        .idx (lv_top),
        .any (any_level)
    );

    assign tid    = TASK_W'(item.task_id);
    assign tid_ok = (32'(item.task_id) < TASKS);
    assign lv_ins = (32'(item.prio) >= LEVELS) ? LVL_W'(LEVELS - 1) : LVL_W'(item.prio);

    always_comb begin
        unique case (item.cmd)
            brq_pkg::CMD_INSERT: lv_sel = lv_ins;
            brq_pkg::CMD_REMOVE: lv_sel = task_level_reg[tid];
            default:             lv_sel = lv_top;
        endcase
    end

    assign head_rd = level_head_reg[lv_sel];
    assign tail_rd = level_tail_reg[lv_sel];
    assign first   = (head_rd == tid);
    assign last    = (tail_rd == tid);

    always_comb begin
        level_bitmap_next = level_bitmap_reg;
        is_queued_next    = is_queued_reg;
        tl_we   = 1'b0;
        nl_we   = 1'b0;
        nl_addr = tid;
        nl_data = head_rd;
        pl_we   = 1'b0;
        pl_addr = tid;
        pl_data = tail_rd;
        hd_we   = 1'b0;
        hd_data = tid;
        tt_we   = 1'b0;
        tt_data = tid;
        result.next_task = '0;
        result.found     = 1'b0;
        result.status    = brq_pkg::STATUS_OK;

        unique case (item.cmd)
            brq_pkg::CMD_INSERT: begin
                if (!tid_ok || is_queued_reg[tid]) begin
                    result.status = brq_pkg::STATUS_INS_IGNORED;
                end else begin
                    tl_we = 1'b1;
                    is_queued_next[tid]       = 1'b1;
                    level_bitmap_next[lv_sel] = 1'b1;
                    if (!level_bitmap_reg[lv_sel]) begin
                        hd_we = 1'b1;
                        tt_we = 1'b1;
                    end else if (item.slice_left) begin
                        nl_we   = 1'b1;
                        nl_addr = tid;
                        nl_data = head_rd;
                        pl_we   = 1'b1;
                        pl_addr = head_rd;
                        pl_data = tid;
                        hd_we   = 1'b1;
                    end else begin
                        pl_we   = 1'b1;
                        pl_addr = tid;
                        pl_data = tail_rd;
                        nl_we   = 1'b1;
                        nl_addr = tail_rd;
                        nl_data = tid;
                        tt_we   = 1'b1;
                    end
                end
            end
            brq_pkg::CMD_REMOVE: begin
                if (!tid_ok || !is_queued_reg[tid]) begin
                    result.status = brq_pkg::STATUS_REM_IGNORED;
                end else begin
                    is_queued_next[tid] = 1'b0;
                    if (first && last) begin
                        level_bitmap_next[lv_sel] = 1'b0;
                    end else if (first) begin
                        hd_we   = 1'b1;
                        hd_data = next_link_reg[tid];
                    end else if (last) begin
                        tt_we   = 1'b1;
                        tt_data = prev_link_reg[tid];
                    end else begin
                        nl_we   = 1'b1;
                        nl_addr = prev_link_reg[tid];
                        nl_data = next_link_reg[tid];
                        pl_we   = 1'b1;
                        pl_addr = next_link_reg[tid];
                        pl_data = prev_link_reg[tid];
                    end
                end
            end
            brq_pkg::CMD_FIND: begin
                if (any_level) begin
                    result.next_task = brq_pkg::FIELD_W'(head_rd);
                    result.found     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_bitmap_reg <= '0;
            is_queued_reg    <= '0;
        end else if (exec_en) begin
            level_bitmap_reg <= level_bitmap_next;
            is_queued_reg    <= is_queued_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_en) begin
            if (tl_we) begin
                task_level_reg[tid] <= lv_sel;
            end
            if (nl_we) begin
                next_link_reg[nl_addr] <= nl_data;
            end
            if (pl_we) begin
                prev_link_reg[pl_addr] <= pl_data;
            end
            if (hd_we) begin
                level_head_reg[lv_sel] <= hd_data;
            end
            if (tt_we) begin
                level_tail_reg[lv_sel] <= tt_data;
            end
        end
    end

endmodule

@@ hw/rtl/bitmap_priority_run_queue.sv @@
// ============================================================================
// bitmap_priority_run_queue
// Priority run queue: one linked list of task ids per level, a level bitmap,
// insert / remove / find commands, one result item per command.
// ============================================================================
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------
//  s_      | in  | s_tvalid/s_tready | s_tuser: cmd; s_tdata: id, prio, slice
//  m_      | out | m_tvalid/m_tready | m_tdata: next_task, found, status
//
//  One item per cycle sustained while m_tready is high; each item passes
//  through the input and result registers and executes combinationally between
//  them, through the level priority encoder and the head/tail pointer lookups.
//  aresetn (synchronous) empties the queue; no clearing pass is needed.
//  A stalled m_ holds its result; the input register still takes one item.
// ============================================================================
`include "bitmap_priority_run_queue_defines.svh"

module bitmap_priority_run_queue #(
    parameter int LEVELS = 32,
    parameter int TASKS  = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [4:0] task_id, [9:5] prio, [10] slice_left, [15:11] zero
    input  logic [brq_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] cmd
    input  logic [brq_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [4:0] next_task, [5] found, [7:6] status
    output logic [brq_pkg::M_TDATA_W-1:0]   m_tdata
);

    brq_pkg::item_t   item_reg;
    logic             item_valid_reg, item_valid_next;
    brq_pkg::result_t res_reg;
    logic             res_valid_reg, res_valid_next;
    brq_pkg::result_t core_res;
    logic             adv;
    logic             s_fire;
    logic             res_found;
    logic             res_ok;
    logic             non_find_adv;
    logic             res_zero;

    assign adv      = item_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || adv;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        item_valid_next = item_valid_reg;
        if (s_fire) begin
            item_valid_next = 1'b1;
        end else if (adv) begin
            item_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (adv) begin
            res_valid_next = 1'b1;
        end else if (m_tready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.cmd        <= s_tuser;
            item_reg.task_id    <= s_tdata[4:0];
            item_reg.prio       <= s_tdata[9:5];
            item_reg.slice_left <= s_tdata[10];
        end
        if (adv) begin
            res_reg <= core_res;
        end
    end

    brq_queue_core #(
        .LEVELS (LEVELS),
        .TASKS  (TASKS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec_en (adv),
        .item    (item_reg),
        .result  (core_res)
    );

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {res_reg.status, res_reg.found, res_reg.next_task};

    assign res_found    = res_valid_reg && res_reg.found;
    assign res_ok       = (res_reg.status == brq_pkg::STATUS_OK);
    assign non_find_adv = adv && (item_reg.cmd != brq_pkg::CMD_FIND);
    assign res_zero     = !res_reg.found && (res_reg.next_task == '0);

    `BRQ_ASSERT_RST(a_adv_gives_result, aclk, aresetn, adv |=> res_valid_reg)
    `BRQ_ASSERT_RST(a_found_only_ok, aclk, aresetn, res_found |-> res_ok)
    `BRQ_ASSERT_RST(a_found_only_find, aclk, aresetn, non_find_adv |=> res_zero)
    `BRQ_ASSERT_RST(a_item_held, aclk, aresetn, item_valid_reg && !adv |=> item_valid_reg && $stable(item_reg))

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: bitmap_priority_run_queue testbench
// A short table of directed commands, then about 1650 random insert, remove,
// find and no-op items sent in phases with random gaps on both channels.
// Every result item is compared with a software copy of the run queue (or, for
// fixed table rows, with the row's value): level bitmap, per-level lists, links.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES     = 11;
    localparam int PHASE_LEN  = 150;

    localparam logic [7:0] WANT_NONE    = {brq_pkg::STATUS_OK, 1'b0, 5'd0};
    localparam logic [7:0] WANT_INS_IGN = {brq_pkg::STATUS_INS_IGNORED, 1'b0, 5'd0};
    localparam logic [7:0] WANT_REM_IGN = {brq_pkg::STATUS_REM_IGNORED, 1'b0, 5'd0};

    typedef struct {
        brq_pkg::item_t it;
        bit             fixed;
        logic [7:0]     want;   // {status, found, next_task}
    } step_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [brq_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [brq_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [brq_pkg::M_TDATA_W-1:0] m_tdata;

    // copy of the run queue
    logic [31:0] lvl_map = '0;
    bit          queued [32];
    logic [4:0]  t_level [32];
    logic [4:0]  nxt [32];
    logic [4:0]  prv [32];
    logic [4:0]  head [32];
    logic [4:0]  tail [32];

    logic [7:0] due_results [$];
    bit         row_fixed = 1'b0;
    logic [7:0] row_want = '0;
    bit         calm = 1'b0;
    int         fails = 0;
    int         idle_cycles = 0;

    step_row_t plan [25] = '{
        '{'{brq_pkg::CMD_FIND,   5'd0,  5'd0,  1'b0}, 1'b1, WANT_NONE},
        '{'{brq_pkg::CMD_NOP,    5'd31, 5'd31, 1'b1}, 1'b1, WANT_NONE},
        '{'{brq_pkg::CMD_REMOVE, 5'd0,  5'd0,  1'b0}, 1'b1, WANT_REM_IGN},
        '{'{brq_pkg::CMD_INSERT, 5'd0,  5'd0,  1'b0}, 1'b1, WANT_NONE},
        '{'{brq_pkg::CMD_FIND,   5'd0,  5'd0,  1'b0}, 1'b1, {brq_pkg::STATUS_OK, 1'b1, 5'd0}},
        '{'{brq_pkg::CMD_INSERT, 5'd0,  5'd31, 1'b1}, 1'b1, WANT_INS_IGN},
        '{'{brq_pkg::CMD_INSERT, 5'd31, 5'd31, 1'b1}, 1'b1, WANT_NONE},
        '{'{brq_pkg::CMD_FIND,   5'd0,  5'd0,  1'b0}, 1'b1, {brq_pkg::STATUS_OK, 1'b1, 5'd31}},
        '{'{brq_pkg::CMD_INSERT, 5'd5,  5'd31, 1'b0}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_INSERT, 5'd7,  5'd31, 1'b1}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_FIND,   5'd31, 5'd31, 1'b1}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_INSERT, 5'd9,  5'd31, 1'b0}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_REMOVE, 5'd5,  5'd0,  1'b0}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_REMOVE, 5'd7,  5'd0,  1'b0}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_FIND,   5'd0,  5'd0,  1'b0}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_REMOVE, 5'd9,  5'd0,  1'b0}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_REMOVE, 5'd31, 5'd0,  1'b0}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_FIND,   5'd0,  5'd0,  1'b0}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_INSERT, 5'd12, 5'd16, 1'b1}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_FIND,   5'd0,  5'd0,  1'b0}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_REMOVE, 5'd0,  5'd0,  1'b0}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_REMOVE, 5'd12, 5'd0,  1'b0}, 1'b0, 8'h00},
        '{'{brq_pkg::CMD_FIND,   5'd0,  5'd0,  1'b0}, 1'b1, WANT_NONE},
        '{'{brq_pkg::CMD_REMOVE, 5'd12, 5'd0,  1'b0}, 1'b1, WANT_REM_IGN},
        '{'{brq_pkg::CMD_NOP,    5'd0,  5'd0,  1'b0}, 1'b1, WANT_NONE}
    };

    bitmap_priority_run_queue uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // applies one command to the queue copy, returns {status, found, next_task}
    function automatic logic [7:0] run_queue_step(brq_pkg::item_t it);
        logic [4:0]                   t;
        logic [4:0]                   lv;
        logic [4:0]                   nt;
        logic                         fnd;
        logic [brq_pkg::STATUS_W-1:0] st;
        bit                           at_first;
        bit                           at_last;
        nt  = '0;
        fnd = 1'b0;
        st  = brq_pkg::STATUS_OK;
        t   = it.task_id;
        case (it.cmd)
            brq_pkg::CMD_INSERT: begin
                if (queued[t]) begin
                    st = brq_pkg::STATUS_INS_IGNORED;
                end else begin
                    lv = it.prio;
                    if (lvl_map[lv]) begin
                        if (it.slice_left) begin
                            nxt[t] = head[lv];
                            prv[head[lv]] = t;
                            head[lv] = t;
                        end else begin
                            prv[t] = tail[lv];
                            nxt[tail[lv]] = t;
                            tail[lv] = t;
                        end
                    end else begin
                        head[lv] = t;
                        tail[lv] = t;
                    end
                    t_level[t] = lv;
                    queued[t] = 1'b1;
                    lvl_map[lv] = 1'b1;
                end
            end
            brq_pkg::CMD_REMOVE: begin
                if (!queued[t]) begin
                    st = brq_pkg::STATUS_REM_IGNORED;
                end else begin
                    lv = t_level[t];
                    at_first = (head[lv] == t);
                    at_last  = (tail[lv] == t);
                    if (at_first && at_last) begin
                        lvl_map[lv] = 1'b0;
                    end else if (at_first) begin
                        head[lv] = nxt[t];
                    end else if (at_last) begin
                        tail[lv] = prv[t];
                    end else begin
                        nxt[prv[t]] = nxt[t];
                        prv[nxt[t]] = prv[t];
                    end
                    queued[t] = 1'b0;
                end
            end
            brq_pkg::CMD_FIND: begin
                if (lvl_map != '0) begin
                    lv = '0;
                    for (int i = 0; i < 32; i++) begin
                        if (lvl_map[i]) lv = 5'(i);
                    end
                    nt  = head[lv];
                    fnd = 1'b1;
                end
            end
            default: ;
        endcase
        return {st, fnd, nt};
    endfunction

    task automatic send_item(input brq_pkg::item_t it, input bit fixed, input logic [7:0] want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid  = 1'b1;
        s_tdata   = {5'd0, it.slice_left, it.prio, it.task_id};
        s_tuser   = it.cmd;
        row_fixed = fixed;
        row_want  = want;
        do @(posedge aclk); while (!s_tready);
    endtask

    // scoreboard and watchdog
    always @(posedge aclk) begin
        logic [7:0]     due;
        brq_pkg::item_t got_item;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $error("result item 0x%02h with none expected", m_tdata);
                    fails++;
                end else begin
                    due = due_results.pop_front();
                    if (m_tdata[4:0] !== due[4:0]) begin
                        $error("next_task: expected %0d, got %0d", due[4:0], m_tdata[4:0]);
                        fails++;
                    end
                    if (m_tdata[5] !== due[5]) begin
                        $error("found: expected %0d, got %0d", due[5], m_tdata[5]);
                        fails++;
                    end
                    if (m_tdata[7:6] !== due[7:6]) begin
                        $error("status: expected %0d, got %0d", due[7:6], m_tdata[7:6]);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                got_item.cmd        = s_tuser;
                got_item.task_id    = s_tdata[4:0];
                got_item.prio       = s_tdata[9:5];
                got_item.slice_left = s_tdata[10];
                due = run_queue_step(got_item);
                due_results.push_back(row_fixed ? row_want : due);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("bitmap_priority_run_queue test failed");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 12);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        brq_pkg::item_t it;
        int             pool [32];
        int             cnt;
        int             pick;
        bit             want_queued;
        bit             narrow;
        foreach (queued[k]) queued[k] = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        foreach (plan[r]) send_item(plan[r].it, plan[r].fixed, plan[r].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            calm   = (ph % 4 == 3);
            narrow = (ph % 2 == 0);
            if (ph == 5) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                while (due_results.size() != 0) @(posedge aclk);
            end
            for (int n = 0; n < PHASE_LEN; n++) begin
                pick          = $urandom_range(0, 99);
                it.task_id    = 5'($urandom_range(0, 31));
                it.slice_left = 1'($urandom_range(0, 1));
                if (narrow) begin
                    it.prio = $urandom_range(0, 1) ? 5'($urandom_range(0, 2))
                                                   : 5'($urandom_range(29, 31));
                end else begin
                    it.prio = 5'($urandom_range(0, 31));
                end
                if (pick < 40) it.cmd = brq_pkg::CMD_INSERT;
                else if (pick < 70) it.cmd = brq_pkg::CMD_REMOVE;
                else if (pick < 95) it.cmd = brq_pkg::CMD_FIND;
                else it.cmd = brq_pkg::CMD_NOP;
                // mostly well-formed: insert idle tasks, remove queued ones
                if ((it.cmd == brq_pkg::CMD_INSERT || it.cmd == brq_pkg::CMD_REMOVE)
                        && $urandom_range(0, 99) < 85) begin
                    want_queued = (it.cmd == brq_pkg::CMD_REMOVE);
                    cnt = 0;
                    for (int k = 0; k < 32; k++) begin
                        if (queued[k] == want_queued) begin
                            pool[cnt] = k;
                            cnt++;
                        end
                    end
                    if (cnt > 0) it.task_id = 5'(pool[$urandom_range(0, cnt - 1)]);
                end
                send_item(it, 1'b0, 8'h00);
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        calm = 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (fails == 0) begin
            $display("bitmap_priority_run_queue test passed");
        end else begin
            $display("bitmap_priority_run_queue test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/brq_pkg.sv
hw/rtl/brq_prio_enc.sv
hw/rtl/brq_queue_core.sv
hw/rtl/bitmap_priority_run_queue.sv
test/tb.sv
